// File: hdl/kft_pkg.sv
// Shared constants, types and codes for the kinetic fling tracker.
package kft_pkg;

    // History of touch points.
    localparam int HIST_DEPTH = 8;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

    // Field widths.
    localparam int OP_W     = 3;
    localparam int POS_W    = 12;
    localparam int TS_W     = 32;
    localparam int DAMP_W   = 16;
    localparam int VALUE_W  = 15;
    localparam int WIN_W    = 8;
    localparam int GAIN_W   = 4;
    localparam int THRESH_W = 17;
    localparam int VEL_W    = 32;

    // Serial divider sizes: a Q16.16 numerator over a span that fits the window.
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = WIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Opcodes.
    localparam logic [OP_W-1:0] OP_PRESS     = 3'd0;
    localparam logic [OP_W-1:0] OP_MOVE      = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE   = 3'd2;
    localparam logic [OP_W-1:0] OP_FLING     = 3'd3;
    localparam logic [OP_W-1:0] OP_FLING_DMP = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DAMPING   = 2'd0;
    localparam logic [1:0] REG_WINDOW    = 2'd1;
    localparam logic [1:0] REG_GAIN      = 2'd2;
    localparam logic [1:0] REG_THRESHOLD = 2'd3;

    // Reset values of the registers.
    localparam logic [DAMP_W-1:0]   RST_DAMPING   = 16'd58982;
    localparam logic [WIN_W-1:0]    RST_WINDOW    = 8'd25;
    localparam logic [GAIN_W-1:0]   RST_GAIN      = 4'd4;
    localparam logic [THRESH_W-1:0] RST_THRESHOLD = 17'd65536;

    // Saturation bounds.
    localparam logic [VEL_W-1:0]   VEL_MAX   = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0]   VEL_MIN   = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 15'h3FFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 15'h4000;

    // Request to the serial divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

endpackage

// File: hdl/kft_div.sv
// Restoring serial divider that retires one quotient bit per cycle.
module kft_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kft_pkg::div_req_t             req,
    output logic                          done,
    output logic [kft_pkg::DIV_NUM_W-1:0] quot
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [kft_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [kft_pkg::DIV_NUM_W-1:0] quo_reg;
    logic [kft_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [kft_pkg::DIV_DEN_W-1:0] den_reg;

    logic [kft_pkg::DIV_DEN_W:0]   trial;
    logic                          fits;
    logic                          last_bit;

    // The partial remainder stays below the divisor, so one extra bit holds the trial.
    assign trial    = {rem_reg, quo_reg[kft_pkg::DIV_NUM_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign last_bit = (cnt_reg == kft_pkg::DIV_CNT_W'(kft_pkg::DIV_NUM_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !req.start && last_bit;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_bit) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[kft_pkg::DIV_NUM_W-2:0], fits};
            if (fits) begin
                rem_reg <= kft_pkg::DIV_DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[kft_pkg::DIV_DEN_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// File: hdl/kinetic_fling_tracker_top.sv
// Top level of the kinetic fling tracker: stream ports, registers, history and sequencer.
// Path: press, move, ignored words and releases that skip the divider go straight to
// ST_OUT; fling ticks pass ST_MUL (one 32x16 multiply) then ST_DAMP (rounding); other
// releases wait in ST_DIV on the serial divider, which retires one quotient bit per
// cycle over 32 bits. Throughput: one word in flight; the input is ready again once
// the result is loaded into the output register. Reset (aresetn low, synchronous)
// clears the sequencer, the pressed flag, the history count, the velocity and the registers.
module kinetic_fling_tracker_top (
    input  logic        aclk,
    input  logic        aresetn,

    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] opcode, [14:3] position, [46:15] timestamp, [62:47] damping, [63] zero
    input  logic [63:0] s_tdata,

    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] value, [15] captured
    output logic [15:0] m_tdata,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DAMP,
        ST_DIV,
        ST_OUT
    } state_t;

    // Input field slices.
    logic [kft_pkg::OP_W-1:0]   in_op;
    logic [kft_pkg::POS_W-1:0]  in_pos;
    logic [kft_pkg::TS_W-1:0]   in_ts;
    logic [kft_pkg::DAMP_W-1:0] in_damp;

    assign in_op   = s_tdata[2:0];
    assign in_pos  = s_tdata[14:3];
    assign in_ts   = s_tdata[46:15];
    assign in_damp = s_tdata[62:47];

    // Configuration registers.
    logic [kft_pkg::DAMP_W-1:0]   damping_reg;
    logic [kft_pkg::WIN_W-1:0]    window_reg;
    logic [kft_pkg::GAIN_W-1:0]   gain_reg;
    logic [kft_pkg::THRESH_W-1:0] thresh_reg;
    logic [1:0]                   reg_idx;
    logic                         cfg_wr;

    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damping_reg <= kft_pkg::RST_DAMPING;
            window_reg  <= kft_pkg::RST_WINDOW;
            gain_reg    <= kft_pkg::RST_GAIN;
            thresh_reg  <= kft_pkg::RST_THRESHOLD;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                kft_pkg::REG_DAMPING:   damping_reg <= pwdata[kft_pkg::DAMP_W-1:0];
                kft_pkg::REG_WINDOW:    window_reg  <= pwdata[kft_pkg::WIN_W-1:0];
                kft_pkg::REG_GAIN:      gain_reg    <= pwdata[kft_pkg::GAIN_W-1:0];
                kft_pkg::REG_THRESHOLD: thresh_reg  <= pwdata[kft_pkg::THRESH_W-1:0];
                default:                damping_reg <= damping_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            kft_pkg::REG_DAMPING:   prdata = 32'(damping_reg);
            kft_pkg::REG_WINDOW:    prdata = 32'(window_reg);
            kft_pkg::REG_GAIN:      prdata = 32'(gain_reg);
            kft_pkg::REG_THRESHOLD: prdata = 32'(thresh_reg);
            default:                prdata = '0;
        endcase
    end

    // Sequencer state and result registers.
    state_t                      state_reg;
    logic                        pressed_reg;
    logic [kft_pkg::HIST_CNT_W-1:0] hist_cnt_reg;
    logic [kft_pkg::VEL_W-1:0]   vel_reg;
    logic                        neg_reg;
    logic [kft_pkg::DAMP_W-1:0]  damp_reg;
    logic [47:0]                 prod_reg;
    logic [kft_pkg::VALUE_W-1:0] res_value_reg;
    logic                        res_capt_reg;
    logic                        m_valid_reg;
    logic [15:0]                 m_data_reg;
    logic [kft_pkg::POS_W-1:0]   last_pos_reg;

    // History: entry 0 is always the oldest point, so only it is read by release.
    logic [kft_pkg::POS_W-1:0]   hist_pos_reg  [kft_pkg::HIST_DEPTH];
    logic [kft_pkg::TS_W-1:0]    hist_time_reg [kft_pkg::HIST_DEPTH];

    logic accept;
    logic do_press;
    logic do_move;
    logic hist_full;
    logic hist_shift;
    logic hist_wr;
    logic [kft_pkg::HIST_IDX_W-1:0] hist_widx;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign do_press = accept && (in_op == kft_pkg::OP_PRESS);
    assign do_move  = accept && (in_op == kft_pkg::OP_MOVE) && pressed_reg;

    assign hist_full  = hist_cnt_reg >= kft_pkg::HIST_CNT_W'(kft_pkg::HIST_DEPTH);
    assign hist_shift = do_move && hist_full;
    assign hist_wr    = do_press || do_move;

    always_comb begin
        if (do_press) begin
            hist_widx = '0;
        end else if (hist_full) begin
            hist_widx = kft_pkg::HIST_IDX_W'(kft_pkg::HIST_DEPTH - 1);
        end else begin
            hist_widx = hist_cnt_reg[kft_pkg::HIST_IDX_W-1:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < kft_pkg::HIST_DEPTH; g++) begin : g_hist
            logic [kft_pkg::POS_W-1:0] pos_src;
            logic [kft_pkg::TS_W-1:0]  time_src;

            if (g < kft_pkg::HIST_DEPTH - 1) begin : g_shift
                assign pos_src  = hist_pos_reg[g+1];
                assign time_src = hist_time_reg[g+1];
            end else begin : g_tail
                assign pos_src  = hist_pos_reg[g];
                assign time_src = hist_time_reg[g];
            end

            always_ff @(posedge aclk) begin
                if (hist_wr && hist_widx == kft_pkg::HIST_IDX_W'(g)) begin
                    hist_pos_reg[g]  <= in_pos;
                    hist_time_reg[g] <= in_ts;
                end else if (hist_shift) begin
                    hist_pos_reg[g]  <= pos_src;
                    hist_time_reg[g] <= time_src;
                end
            end
        end
    endgenerate

    // Release: span from the oldest point, widened to at least one tick.
    logic [kft_pkg::POS_W-1:0] rel_cur;
    logic [kft_pkg::TS_W-1:0]  rel_span_raw;
    logic [kft_pkg::TS_W-1:0]  rel_span;
    logic                      rel_ok;
    logic [kft_pkg::POS_W:0]   rel_diff;
    logic [kft_pkg::POS_W-1:0] rel_mag;
    logic [15:0]               rel_scaled;
    kft_pkg::div_req_t         div_req;
    logic                      div_done;
    logic [kft_pkg::DIV_NUM_W-1:0] div_quot;

    assign rel_cur      = (in_pos == '0) ? last_pos_reg : in_pos;
    assign rel_span_raw = in_ts - hist_time_reg[0];
    assign rel_span     = (rel_span_raw == '0) ? kft_pkg::TS_W'(1) : rel_span_raw;
    assign rel_ok       = rel_span <= kft_pkg::TS_W'(window_reg);
    assign rel_diff     = {1'b0, hist_pos_reg[0]} - {1'b0, rel_cur};
    assign rel_mag      = rel_diff[kft_pkg::POS_W] ?
                          kft_pkg::POS_W'(-rel_diff) : rel_diff[kft_pkg::POS_W-1:0];
    assign rel_scaled   = 16'(rel_mag) * 16'(gain_reg);

    assign div_req.start = accept && (in_op == kft_pkg::OP_RELEASE) && pressed_reg && rel_ok;
    assign div_req.num   = {rel_scaled, 16'h0000};
    assign div_req.den   = rel_span[kft_pkg::DIV_DEN_W-1:0];

    kft_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Velocity from the quotient, saturated to the signed 32-bit range.
    logic [kft_pkg::VEL_W-1:0] div_vel;

    always_comb begin
        if (neg_reg) begin
            div_vel = div_quot[31] ? kft_pkg::VEL_MIN : kft_pkg::VEL_W'(-div_quot);
        end else begin
            div_vel = div_quot[31] ? kft_pkg::VEL_MAX : div_quot;
        end
    end

    // Fling tick: magnitude times damping; a positive Q16.16 result is rounded up, a negative one toward zero.
    logic [kft_pkg::VEL_W-1:0] vel_mag;
    logic [kft_pkg::VEL_W-1:0] damp_scaled;
    logic [15:0]               damp_hi;
    logic [15:0]               damp_ceil;
    logic                      damp_below;
    logic [kft_pkg::VALUE_W-1:0] damp_value;

    assign vel_mag     = vel_reg[31] ? kft_pkg::VEL_W'(-vel_reg) : vel_reg;
    assign damp_scaled = prod_reg[47:16];
    assign damp_hi     = damp_scaled[31:16];
    assign damp_ceil   = damp_hi + 16'(damp_scaled[15:0] != '0);
    assign damp_below  = damp_scaled < kft_pkg::VEL_W'(thresh_reg);

    always_comb begin
        if (damp_below) begin
            damp_value = '0;
        end else if (neg_reg) begin
            damp_value = (damp_hi > 16'd16384) ? kft_pkg::VALUE_MIN :
                         kft_pkg::VALUE_W'(-damp_hi);
        end else begin
            damp_value = (damp_ceil > 16'd16383) ? kft_pkg::VALUE_MAX :
                         damp_ceil[kft_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pressed_reg   <= 1'b0;
            hist_cnt_reg  <= '0;
            vel_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // The output register is loaded from ST_OUT and empties when its word is taken.
            if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (in_op)
                            kft_pkg::OP_PRESS: begin
                                pressed_reg   <= 1'b1;
                                vel_reg       <= '0;
                                hist_cnt_reg  <= kft_pkg::HIST_CNT_W'(1);
                                last_pos_reg  <= in_pos;
                                res_value_reg <= '0;
                                res_capt_reg  <= 1'b0;
                                state_reg     <= ST_OUT;
                            end
                            kft_pkg::OP_MOVE: begin
                                state_reg <= ST_OUT;
                                if (pressed_reg) begin
                                    res_value_reg <= kft_pkg::VALUE_W'(last_pos_reg) -
                                                     kft_pkg::VALUE_W'(in_pos);
                                    res_capt_reg  <= 1'b1;
                                    last_pos_reg  <= in_pos;
                                    if (!hist_full) begin
                                        hist_cnt_reg <= hist_cnt_reg + 1'b1;
                                    end
                                end else begin
                                    res_value_reg <= '0;
                                    res_capt_reg  <= 1'b0;
                                end
                            end
                            kft_pkg::OP_RELEASE: begin
                                // Any release ends the gesture; only a short one
                                // goes on to the divider.
                                pressed_reg   <= 1'b0;
                                res_value_reg <= '0;
                                res_capt_reg  <= div_req.start;
                                if (div_req.start) begin
                                    neg_reg   <= rel_diff[kft_pkg::POS_W];
                                    state_reg <= ST_DIV;
                                end else begin
                                    state_reg <= ST_OUT;
                                end
                            end
                            kft_pkg::OP_FLING: begin
                                damp_reg     <= damping_reg;
                                res_capt_reg <= 1'b0;
                                state_reg    <= ST_MUL;
                            end
                            kft_pkg::OP_FLING_DMP: begin
                                damp_reg     <= in_damp;
                                res_capt_reg <= 1'b0;
                                state_reg    <= ST_MUL;
                            end
                            default: begin
                                res_value_reg <= '0;
                                res_capt_reg  <= 1'b0;
                                state_reg     <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    // Sign is kept aside; the product is of the magnitude.
                    neg_reg   <= vel_reg[31];
                    prod_reg  <= 48'(vel_mag) * 48'(damp_reg);
                    state_reg <= ST_DAMP;
                end
                ST_DAMP: begin
                    vel_reg       <= neg_reg ? kft_pkg::VEL_W'(-damp_scaled) : damp_scaled;
                    res_value_reg <= damp_value;
                    state_reg     <= ST_OUT;
                end
                ST_DIV: begin
                    if (div_done) begin
                        vel_reg   <= div_vel;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg <= {res_capt_reg, res_value_reg};
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: bench/kinetic_fling_tracker_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the kinetic fling tracker top level.
module kinetic_fling_tracker_top_test;

    // Watchdog limit in cycles without any handshake. The longest legal quiet
    // stretch is the receiver hold-off plus a long gap, well under this.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    // A release waits on the serial divider, so this covers any straggler.
    localparam int DRAIN_CYCLES    = 60;
    localparam int WORDS_PER_PHASE = 165;
    localparam int MAX_REPORTS     = 10;

    localparam longint VEL_HI  = 2147483647;
    localparam longint VEL_LO  = -VEL_HI - 1;
    localparam longint STEP_HI = 16383;
    localparam longint STEP_LO = -16384;
    localparam longint ONE_Q16 = 65536;

    // Input word as it sits in s_tdata, lowest field last.
    typedef struct packed {
        logic                       pad;
        logic [kft_pkg::DAMP_W-1:0] damping;
        logic [kft_pkg::TS_W-1:0]   timestamp;
        logic [kft_pkg::POS_W-1:0]  position;
        logic [kft_pkg::OP_W-1:0]   opcode;
    } touch_word_t;

    // Result word as it sits in m_tdata.
    typedef struct packed {
        logic                               captured;
        logic signed [kft_pkg::VALUE_W-1:0] value;
    } fling_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    kinetic_fling_tracker_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Words waiting to be sent and results the tracker still owes us.
    touch_word_t   pending_words[$];
    fling_result_t owed_results[$];

    int mismatches     = 0;
    int words_queued   = 0;
    int words_accepted = 0;
    int results_seen   = 0;
    int captures_seen  = 0;
    int settings_used  = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    int calm_left[2]   = '{0, 0};

    // Shadow of the configuration registers, updated when we write them.
    logic [kft_pkg::DAMP_W-1:0]   cfg_damping   = kft_pkg::RST_DAMPING;
    logic [kft_pkg::WIN_W-1:0]    cfg_window    = kft_pkg::RST_WINDOW;
    logic [kft_pkg::GAIN_W-1:0]   cfg_gain      = kft_pkg::RST_GAIN;
    logic [kft_pkg::THRESH_W-1:0] cfg_threshold = kft_pkg::RST_THRESHOLD;

    // Our own copy of the gesture state.
    bit                        track_pressed  = 1'b0;
    logic [kft_pkg::POS_W-1:0] track_pos[kft_pkg::HIST_DEPTH];
    logic [kft_pkg::TS_W-1:0]  track_time[kft_pkg::HIST_DEPTH];
    int unsigned               track_count    = 0;
    longint                    track_velocity = 0;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    function automatic longint clamp_velocity(input longint v);
        if (v > VEL_HI) return VEL_HI;
        if (v < VEL_LO) return VEL_LO;
        return v;
    endfunction

    // One fling tick: scale the velocity magnitude by a Q0.16 factor, then round a
    // positive step up and a negative one toward zero unless the result fell under the threshold.
    function automatic longint damp_velocity(input logic [kft_pkg::DAMP_W-1:0] factor);
        longint mag;
        longint scaled;
        mag = (track_velocity < 0) ? -track_velocity : track_velocity;
        scaled = (mag * longint'(factor)) >> 16;
        track_velocity = clamp_velocity((track_velocity < 0) ? -scaled : scaled);
        mag = (track_velocity < 0) ? -track_velocity : track_velocity;
        if (mag < longint'(cfg_threshold)) return 0;
        if (track_velocity >= 0) return (track_velocity + ONE_Q16 - 1) / ONE_Q16;
        return -(mag / ONE_Q16);
    endfunction

    // Works out the result of one accepted word and advances the gesture state.
    function automatic fling_result_t predict_fling(input touch_word_t w);
        fling_result_t             r;
        longint                    step;
        longint                    diff;
        longint                    mag;
        longint                    quot;
        int unsigned               last;
        logic [kft_pkg::POS_W-1:0] cur;
        logic [kft_pkg::TS_W-1:0]  span;
        int                        i;
        step = 0;
        r.captured = 1'b0;
        last = (track_count == 0 || track_count > kft_pkg::HIST_DEPTH) ? 0 : track_count - 1;
        case (w.opcode)
            kft_pkg::OP_PRESS: begin
                track_pressed = 1'b1;
                track_velocity = 0;
                track_count = 1;
                track_pos[0] = w.position;
                track_time[0] = w.timestamp;
            end
            kft_pkg::OP_MOVE: begin
                if (track_pressed) begin
                    step = longint'(track_pos[last]) - longint'(w.position);
                    if (track_count >= kft_pkg::HIST_DEPTH) begin
                        // History full: the oldest point falls out.
                        for (i = 1; i < kft_pkg::HIST_DEPTH; i++) begin
                            track_pos[i-1] = track_pos[i];
                            track_time[i-1] = track_time[i];
                        end
                        track_count = kft_pkg::HIST_DEPTH;
                    end else begin
                        track_count++;
                    end
                    track_pos[track_count-1] = w.position;
                    track_time[track_count-1] = w.timestamp;
                    r.captured = 1'b1;
                end
            end
            kft_pkg::OP_RELEASE: begin
                if (track_pressed) begin
                    cur = (w.position == '0) ? track_pos[last] : w.position;
                    span = w.timestamp - track_time[0];
                    track_pressed = 1'b0;
                    if (span == '0) span = 1;
                    if (span <= cfg_window) begin
                        diff = longint'(track_pos[0]) - longint'(cur);
                        mag = (diff < 0) ? -diff : diff;
                        quot = (mag * longint'(cfg_gain) * ONE_Q16) / longint'(span);
                        track_velocity = clamp_velocity((diff < 0) ? -quot : quot);
                        r.captured = 1'b1;
                    end
                end
            end
            kft_pkg::OP_FLING:     step = damp_velocity(cfg_damping);
            kft_pkg::OP_FLING_DMP: step = damp_velocity(w.damping);
            default: ;
        endcase
        if (step > STEP_HI) step = STEP_HI;
        if (step < STEP_LO) step = STEP_LO;
        r.value = step[kft_pkg::VALUE_W-1:0];
        return r;
    endfunction

    // Gap lengths: mostly none or short, a few long, and now and then a calm
    // stretch with no gaps at all. Side 0 is the sender, side 1 the receiver.
    function automatic int pick_gap(input int side);
        int roll;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) calm_left[side] = 60;
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Driver: presents the next pending word and predicts each accepted one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                owed_results.push_back(predict_fling(s_tdata));
                words_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_tdata <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest owed result and
    // drives m_tready, including the long hold-off that fills the tracker.
    always @(posedge aclk) begin
        fling_result_t got;
        fling_result_t want;
        logic          ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (got.captured) captures_seen++;
                if (owed_results.size() == 0) begin
                    report_mismatch("result word with nothing owed", 'x, 32'(got));
                end else begin
                    want = owed_results.pop_front();
                    if (got.value !== want.value) begin
                        report_mismatch("value", 32'(want.value), 32'(got.value));
                    end
                    if (got.captured !== want.captured) begin
                        report_mismatch("captured", 32'(want.captured), 32'(got.captured));
                    end
                end
            end
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                stall_left = pick_gap(1);
            end
            m_tready <= ready_next;
        end
    end

    // Watchdog: the run is stuck if no handshake of any kind happens for long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: %0d quiet cycles, %0d results still owed",
                     quiet_cycles, owed_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void add_word(input logic [kft_pkg::OP_W-1:0] op,
                                     input logic [kft_pkg::POS_W-1:0] pos,
                                     input logic [kft_pkg::TS_W-1:0] stamp,
                                     input logic [kft_pkg::DAMP_W-1:0] damp);
        touch_word_t w;
        w = '0;
        w.opcode = op;
        w.position = pos;
        w.timestamp = stamp;
        w.damping = damp;
        pending_words.push_back(w);
        words_queued++;
    endfunction

    // Register write with a read-back, both in setup and access cycles.
    task automatic set_register(input logic [1:0] index, input logic [31:0] data);
        logic [31:0] want;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // The write took place at this edge; now read it back.
        case (index)
            kft_pkg::REG_DAMPING:   cfg_damping = data[kft_pkg::DAMP_W-1:0];
            kft_pkg::REG_WINDOW:    cfg_window = data[kft_pkg::WIN_W-1:0];
            kft_pkg::REG_GAIN:      cfg_gain = data[kft_pkg::GAIN_W-1:0];
            kft_pkg::REG_THRESHOLD: cfg_threshold = data[kft_pkg::THRESH_W-1:0];
            default: ;
        endcase
        case (index)
            kft_pkg::REG_DAMPING:   want = 32'(cfg_damping);
            kft_pkg::REG_WINDOW:    want = 32'(cfg_window);
            kft_pkg::REG_GAIN:      want = 32'(cfg_gain);
            default:                want = 32'(cfg_threshold);
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) report_mismatch("register read-back", want, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_tuning(input logic [kft_pkg::DAMP_W-1:0] damp,
                                input logic [kft_pkg::WIN_W-1:0] win,
                                input logic [kft_pkg::GAIN_W-1:0] gain,
                                input logic [kft_pkg::THRESH_W-1:0] thresh);
        set_register(kft_pkg::REG_DAMPING, 32'(damp));
        set_register(kft_pkg::REG_WINDOW, 32'(win));
        set_register(kft_pkg::REG_GAIN, 32'(gain));
        set_register(kft_pkg::REG_THRESHOLD, 32'(thresh));
        settings_used++;
    endtask

    // Waits until every queued word went in and every owed result came out.
    task automatic wait_idle();
        while (pending_words.size() > 0 || s_tvalid || owed_results.size() > 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Random traffic: mostly whole gestures (press, moves, release, fling
    // ticks) with random content, some gestures cut short, and some noise.
    task automatic queue_random_words(input int target);
        int          first;
        int          moves;
        int          step_max;
        int          k;
        logic [31:0] t;
        first = words_queued;
        while (words_queued - first < target) begin
            if ($urandom_range(0, 99) < 15) begin
                add_word(kft_pkg::OP_W'($urandom_range(0, (1 << kft_pkg::OP_W) - 1)),
                         kft_pkg::POS_W'($urandom_range(0, 4095)),
                         $urandom(), kft_pkg::DAMP_W'($urandom_range(0, 65535)));
            end else begin
                // Start some gestures just before the timestamp wraps.
                t = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                                : $urandom();
                add_word(kft_pkg::OP_PRESS, kft_pkg::POS_W'($urandom_range(0, 4095)), t,
                         kft_pkg::DAMP_W'($urandom_range(0, 65535)));
                moves = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14)
                                                    : $urandom_range(0, 7);
                step_max = $urandom_range(0, cfg_window / 4 + 1);
                for (k = 0; k < moves; k++) begin
                    t += $urandom_range(0, step_max);
                    add_word(kft_pkg::OP_MOVE, kft_pkg::POS_W'($urandom_range(0, 4095)), t,
                             kft_pkg::DAMP_W'($urandom_range(0, 65535)));
                end
                if ($urandom_range(0, 9) != 0) begin
                    t += $urandom_range(0, step_max);
                    add_word(kft_pkg::OP_RELEASE,
                             kft_pkg::POS_W'(($urandom_range(0, 3) == 0) ?
                                             0 : $urandom_range(0, 4095)),
                             t, kft_pkg::DAMP_W'($urandom_range(0, 65535)));
                end
                for (k = $urandom_range(0, 6); k > 0; k--) begin
                    add_word($urandom_range(0, 1) ? kft_pkg::OP_FLING : kft_pkg::OP_FLING_DMP,
                             kft_pkg::POS_W'($urandom_range(0, 4095)), $urandom(),
                             kft_pkg::DAMP_W'(($urandom_range(0, 3) == 0) ?
                                              $urandom_range(0, 65535) :
                                              $urandom_range(50000, 65535)));
                end
            end
        end
    endtask

    initial begin
        int k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset settings. Moves and releases while
        // released, an idle fling and the unused opcodes must all be ignored.
        add_word(kft_pkg::OP_MOVE, 12'd12, 32'd5, '0);
        add_word(kft_pkg::OP_RELEASE, 12'd7, 32'd6, '0);
        add_word(kft_pkg::OP_FLING, '0, '0, '0);
        for (k = int'(kft_pkg::OP_FLING_DMP) + 1; k < (1 << kft_pkg::OP_W); k++) begin
            add_word(kft_pkg::OP_W'(k), '1, '1, '1);
        end
        // Full-scale moves just before the timestamp wrap, then a release whose
        // span wraps too, followed by ticks with full and default damping.
        add_word(kft_pkg::OP_PRESS, 12'd4095, 32'hFFFF_FFF0, '1);
        add_word(kft_pkg::OP_MOVE, 12'd0, 32'hFFFF_FFF4, '0);
        add_word(kft_pkg::OP_MOVE, 12'd4095, 32'hFFFF_FFF8, '1);
        add_word(kft_pkg::OP_RELEASE, 12'd1, 32'h0000_0005, '0);
        add_word(kft_pkg::OP_FLING_DMP, '0, '0, 16'hFFFF);
        add_word(kft_pkg::OP_FLING, '1, '1, '0);
        // Zero span widened to one tick, giving a large negative velocity;
        // a zero damping factor then drops it under the stop threshold.
        add_word(kft_pkg::OP_PRESS, 12'd0, 32'd1000, '0);
        add_word(kft_pkg::OP_RELEASE, 12'd4095, 32'd1000, '0);
        add_word(kft_pkg::OP_FLING_DMP, '0, '0, 16'hFFFF);
        add_word(kft_pkg::OP_FLING_DMP, '0, '0, 16'h0000);
        // A span over the window rejects the release.
        add_word(kft_pkg::OP_PRESS, 12'd2000, 32'd50, '0);
        add_word(kft_pkg::OP_RELEASE, 12'd0, 32'd200, '0);
        // Overflow the history so the oldest point is dropped, then release
        // on the last point.
        add_word(kft_pkg::OP_PRESS, 12'd100, 32'd0, '0);
        for (k = 1; k <= kft_pkg::HIST_DEPTH; k++) begin
            add_word(kft_pkg::OP_MOVE, 12'(100 + 50 * k), 32'(k), '0);
        end
        add_word(kft_pkg::OP_RELEASE, 12'd0, 32'(kft_pkg::HIST_DEPTH + 1), '0);
        queue_random_words(WORDS_PER_PHASE);
        wait_idle();

        // Extremes, and a long receiver hold-off while words keep coming.
        apply_tuning(16'hFFFF, 8'd255, 4'd15, '0);
        hold_requests <= hold_requests + 1;
        queue_random_words(WORDS_PER_PHASE);
        wait_idle();

        // The other ends of the ranges.
        apply_tuning(16'h0000, 8'd1, 4'd1, 17'd65536);
        queue_random_words(WORDS_PER_PHASE);
        wait_idle();

        // Zero gain and zero window are taken as they are.
        apply_tuning(16'h8000, 8'd0, 4'd0, 17'd1);
        queue_random_words(WORDS_PER_PHASE / 2);
        wait_idle();

        for (k = 0; k < 2; k++) begin
            apply_tuning(kft_pkg::DAMP_W'($urandom_range(0, 65535)),
                         kft_pkg::WIN_W'($urandom_range(1, 255)),
                         kft_pkg::GAIN_W'($urandom_range(1, 15)),
                         kft_pkg::THRESH_W'($urandom_range(0, 65536)));
            queue_random_words(WORDS_PER_PHASE);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (owed_results.size() > 0) begin
            mismatches++;
            $display("%0d owed results never came out", owed_results.size());
        end
        $display("Sent %0d touch words over %0d register settings; %0d results checked,",
                 words_accepted, settings_used, results_seen);
        $display("%0d of them captured, %0d mismatches in all.", captures_seen, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/kft_pkg.sv
hdl/kft_div.sv
hdl/kinetic_fling_tracker_top.sv
bench/kinetic_fling_tracker_top_test.sv
